// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define U8_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same-cycle implication
`define U8_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    `U8_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

// next-cycle implication
`define U8_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    `U8_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

// ----- hdl/u8u16_pkg.sv -----
// ---------------------------------------------------------------------------
// u8u16_pkg
// types and constants shared by the utf-8 to utf-16 transcoder modules
// ---------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    // code point limits
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_LEN3  = 21'h010000;
    localparam logic [20:0] CP_MIN_LEN2  = 21'h000800;
    localparam logic [20:0] CP_MIN_LEN1  = 21'h000080;

    // lead byte classes
    localparam logic [7:0]  LEAD_BAD_TOP = 8'hC1;
    localparam logic [7:0]  LEAD_BAD_MIN = 8'hF5;
    localparam logic [7:0]  LEAD_LEN3    = 8'hF0;
    localparam logic [7:0]  LEAD_LEN2    = 8'hE0;
    localparam logic [1:0]  CONT_TAG     = 2'b10;

    // utf-16 surrogate tags (upper six bits)
    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;

    // one result item
    typedef struct packed {
        logic [15:0] unit;
        logic        error;
        logic        end_of_string;
    } result_t;

    // one queue entry: all results caused by one byte
    typedef struct packed {
        logic [1:0]        cnt;
        result_t [2:0]     res;
    } entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

// ----- hdl/utf8_to_utf16_transcoder_core.sv -----
// ---------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// streaming utf-8 to utf-16 transcoder with error reporting
// ---------------------------------------------------------------------------
// channel   dir   payload
// s_        in    tdata[7:0] byte_in
// m_        out   tdata[15:0] unit, tuser[0] error, tuser[1] end_of_string,
//                 tlast last result of the input byte
//
// a byte is taken every cycle while the entry queue has room; the decoder
// turns it into zero to three results in the same cycle
// the emitter drives one result per cycle from the queue head while the
// output register is free, so the sustained byte rate is one per cycle while
// results average one per byte or fewer; the byte that releases a held
// supplementary code point carries two or three results
// synchronous reset (aresetn low) clears decoder, queue and emitter state
// a stalled m_ side fills the queue, after which s_tready drops
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_core #(
    parameter int QUEUE_DEPTH = 4      // entries between decoder and emitter
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // input byte stream
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // [7:0] byte_in
    // utf-16 result stream
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata,    // [15:0] unit
    output logic [1:0]          m_tuser,    // [0] error, [1] end_of_string
    output logic                m_tlast     // last result caused by one byte
);
    import u8u16_pkg::*;

    logic       accept;      // byte request taken this cycle
    logic       push;        // decoder writes an entry
    logic       pop;         // emitter loads the entry's last result
    entry_t     push_entry;
    entry_t     head_entry;
    q_status_t  q_status;

    // front accepts whenever the queue can take a possible entry
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // decoder: sequence tracking and validation
    u8u16_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .byte_in    (s_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples decoding from result delivery
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    // emitter: one result per cycle into the output register while it is free
    u8u16_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .status     (q_status),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ----- hdl/u8u16_queue.sv -----
// ---------------------------------------------------------------------------
// u8u16_queue
// short fifo of decoded entries between the decoder and the emitter
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  u8u16_pkg::entry_t       push_entry,
    input  wire logic               pop,
    output u8u16_pkg::entry_t       head_entry,
    output u8u16_pkg::q_status_t    status
);
    import u8u16_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry   = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// ----- hdl/u8u16_front.sv -----
// ---------------------------------------------------------------------------
// u8u16_front
// utf-8 decoder: sequence state, validity checks, per-byte result entry
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [7:0]     byte_in,
    output logic                push,
    output u8u16_pkg::entry_t   push_entry
);
    import u8u16_pkg::*;

    logic [1:0]  rem_reg,   rem_next;
    logic [1:0]  seq_reg,   seq_next;
    logic [20:0] acc_reg,   acc_next;
    logic        held_reg,  held_next;
    logic        drain_reg, drain_next;

    logic        is_cont;
    logic        is_nul;
    logic [20:0] acc_cont;
    logic [1:0]  rem_dec;
    logic [4:0]  plane_dec;
    logic        err;
    logic [1:0]  n;
    entry_t      ent;

    function automatic logic value_bad(input logic [20:0] v, input logic [1:0] len);
        logic bad;
        bad = (v > CP_MAX)
            || ((v >= CP_SURR_LO) && (v <= CP_SURR_HI))
            || ((len == 2'd3) && (v < CP_MIN_LEN3))
            || ((len == 2'd2) && (v < CP_MIN_LEN2))
            || ((len == 2'd1) && (v < CP_MIN_LEN1));
        return bad;
    endfunction

    assign is_cont   = (byte_in[7:6] == CONT_TAG);
    assign is_nul    = (byte_in == 8'h00);
    assign acc_cont  = {acc_reg[14:0], byte_in[5:0]};
    assign rem_dec   = rem_reg - 2'd1;
    assign plane_dec = acc_reg[20:16] - 5'd1;

    always_comb begin
        rem_next   = rem_reg;
        seq_next   = seq_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        drain_next = drain_reg;
        err        = 1'b0;
        n          = 2'd0;
        ent        = '0;

        if (drain_reg) begin
            // dropping bytes after an error
            if (is_nul) begin
                drain_next = 1'b0;
            end
        end else if (rem_reg != 2'd0) begin
            if (!is_cont) begin
                err = 1'b1;
            end else begin
                acc_next = acc_cont;
                rem_next = rem_dec;
                if (rem_dec == 2'd0) begin
                    if (value_bad(acc_cont, seq_reg)) begin
                        err = 1'b1;
                    end else begin
                        held_next = 1'b1;
                    end
                end
            end
        end else if (held_reg && is_cont) begin
            err = 1'b1;
        end else begin
            if (held_reg) begin
                if (acc_reg[20:16] != 5'd0) begin
                    ent.res[n] = '{unit: {SURR_HIGH_TAG, plane_dec[3:0], acc_reg[15:10]},
                                   error: 1'b0, end_of_string: 1'b0};
                    n = n + 2'd1;
                    ent.res[n] = '{unit: {SURR_LOW_TAG, acc_reg[9:0]},
                                   error: 1'b0, end_of_string: 1'b0};
                    n = n + 2'd1;
                end else begin
                    ent.res[n] = '{unit: acc_reg[15:0], error: 1'b0, end_of_string: 1'b0};
                    n = n + 2'd1;
                end
                rem_next  = 2'd0;
                seq_next  = 2'd0;
                acc_next  = '0;
                held_next = 1'b0;
            end
            // lead byte
            if (is_nul) begin
                ent.res[n] = '{unit: 16'h0000, error: 1'b0, end_of_string: 1'b1};
                n = n + 2'd1;
                rem_next  = 2'd0;
                seq_next  = 2'd0;
                acc_next  = '0;
                held_next = 1'b0;
            end else if (!byte_in[7]) begin
                ent.res[n] = '{unit: {8'h00, byte_in}, error: 1'b0, end_of_string: 1'b0};
                n = n + 2'd1;
            end else if ((byte_in <= LEAD_BAD_TOP) || (byte_in >= LEAD_BAD_MIN)) begin
                err = 1'b1;
            end else if (byte_in >= LEAD_LEN3) begin
                seq_next = 2'd3;
                rem_next = 2'd3;
                acc_next = {18'd0, byte_in[2:0]};
            end else if (byte_in >= LEAD_LEN2) begin
                seq_next = 2'd2;
                rem_next = 2'd2;
                acc_next = {17'd0, byte_in[3:0]};
            end else begin
                seq_next = 2'd1;
                rem_next = 2'd1;
                acc_next = {16'd0, byte_in[4:0]};
            end
        end

        if (err) begin
            ent.res[n] = '{unit: 16'h0000, error: 1'b1, end_of_string: 1'b0};
            n = n + 2'd1;
            rem_next   = 2'd0;
            seq_next   = 2'd0;
            acc_next   = '0;
            held_next  = 1'b0;
            drain_next = !is_nul;
        end
        ent.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= '0;
            seq_reg   <= '0;
            acc_reg   <= '0;
            held_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end else if (accept) begin
            rem_reg   <= rem_next;
            seq_reg   <= seq_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            drain_reg <= drain_next;
        end
    end

    assign push       = accept && (n != 2'd0);
    assign push_entry = ent;

endmodule

`default_nettype wire

// ----- hdl/u8u16_back.sv -----
// ---------------------------------------------------------------------------
// u8u16_back
// emitter: walks each queued entry and drives one result per unstalled cycle
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  u8u16_pkg::entry_t       head_entry,
    input  u8u16_pkg::q_status_t    status,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);
    import u8u16_pkg::*;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;
    logic [1:0]  idx_reg;
    logic        out_free;
    logic        load;
    logic        is_last;
    result_t     cur;

    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = out_free && !status.empty;
    assign is_last  = (idx_reg == (head_entry.cnt - 2'd1));
    assign cur      = head_entry.res[idx_reg];
    assign pop      = load && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            if (out_free) begin
                m_tvalid_reg <= !status.empty;
            end
            if (load) begin
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= cur.unit;
            m_tuser_reg <= {cur.end_of_string, cur.error};
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ----- hdl/u8u16_checker.sv -----
// ---------------------------------------------------------------------------
// u8u16_checker
// port-level checks on the transcoder result stream
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u8u16_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    logic high_surr;

    assign high_surr    = (m_tdata[15:10] == 6'b110110);

    // a stalled result holds
    `U8_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result changed")

    // an error result carries unit zero and ends the byte's results
    `U8_ASSERT_IMP(a_err_shape, aclk, aresetn, m_tvalid && m_tuser[0],
        (m_tdata == 16'h0000) && m_tlast && !m_tuser[1],
        "malformed error result")

    // end of string is unit zero and the last result of its byte
    `U8_ASSERT_IMP(a_eos_shape, aclk, aresetn, m_tvalid && m_tuser[1],
        (m_tdata == 16'h0000) && m_tlast,
        "malformed end of string result")

    // a high surrogate is followed at once by its low half
    `U8_ASSERT_NXT(a_surr_pair, aclk, aresetn,
        m_tvalid && m_tready && high_surr && !m_tlast,
        m_tvalid && (m_tdata[15:10] == 6'b110111) && !m_tuser[0],
        "high surrogate not followed by low surrogate")

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_checker (.*);

`default_nettype wire
